// ===== rtl/ose_pkg.sv =====
// Package for the stub evaluator: parse phases, pending operations, run and end status codes,
// opcode constants and word widths.
// No dependencies.
package ose_pkg;

  localparam int unsigned RegW       = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutFieldsW = RegW + StatusW + RegW + RegW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [RegW-1:0] StartAddrRst = '0;

  localparam logic [ByteW-1:0] OpcRexW     = 8'h48;
  localparam logic [ByteW-1:0] OpcRexWB    = 8'h49;
  localparam logic [ByteW-1:0] OpcMovRax   = 8'hB8;
  localparam logic [ByteW-1:0] OpcMovR10   = 8'hBA;
  localparam logic [ByteW-1:0] OpcGrp5     = 8'hFF;
  localparam logic [ByteW-1:0] ModrmJmpRax = 8'hE0;
  localparam logic [ByteW-1:0] OpcJmpRel   = 8'hE9;
  localparam logic [ByteW-1:0] OpcAddImm   = 8'h05;
  localparam logic [ByteW-1:0] OpcSubImm   = 8'h2D;
  localparam logic [ByteW-1:0] OpcXorImm   = 8'h35;
  localparam logic [ByteW-1:0] OpcEscape   = 8'h0F;
  localparam logic [ByteW-1:0] OpcImul     = 8'hAF;
  localparam logic [ByteW-1:0] ModrmRaxR10 = 8'hC2;

  typedef enum logic [3:0] {
    PH_PRE0,
    PH_PRE1,
    PH_IMM_ACC,
    PH_OPCODE,
    PH_JMPREG,
    PH_REL,
    PH_P48,
    PH_IMM32,
    PH_P49,
    PH_IMM_SEC,
    PH_TWO_BYTE,
    PH_MODRM
  } phase_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_XOR
  } alu_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_RUN  = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

endpackage

// ===== rtl/obfuscated_stub_evaluator.sv =====
// Stub evaluator top level: byte-serial parser and evaluator for a small x86-64 subset.
// Depends on ose_pkg.
//
// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | code_byte
// m_axis   | out | m_axis_tvalid/m_axis_tready | next_address, status, accumulator,
//          |     |                             | multiplier_reg
// cfg      | in  | cfg_we_i                    | start_address
//
// One code byte per cycle unless m_axis stalls; its result shows in the next cycle.
// The result register frees s_axis_tready whenever it is empty or being drained.
// The imul product is built from acc and r10 in a two-stage 32x32 pipeline during the
// three bytes that precede its ModRM byte.
// Reset and a start_address write both restart at the stub head with cleared registers.
module obfuscated_stub_evaluator
  import ose_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegW-1:0]     cfg_wdata_i,     // start_address
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,    // [7:0] code_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata     // [63:0] next_address, [65:64] status,
                                               // [129:66] accumulator,
                                               // [193:130] multiplier_reg, rest zero
);

  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [RegW-1:0] imm_q, imm_d;
  alu_op_e         op_q, op_d;
  logic [RegW-1:0] acc_q, acc_d;
  logic [RegW-1:0] sec_q, sec_d;
  logic [RegW-1:0] ptr_q, ptr_d;
  status_e         st_q, st_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;

  logic [RegW-1:0]   mul_ll_q;
  logic [RegW/2-1:0] mul_x_q;
  logic [RegW-1:0]   prod_q;
  logic [RegW-1:0]   mul_ll;
  logic [RegW/2-1:0] mul_x;

  logic              in_acc;
  logic [ByteW-1:0]  cb;
  logic [RegW-1:0]   imm_word;
  logic [RegW-1:0]   imm_sext;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cb            = s_axis_tdata;
  assign imm_word      = imm_q | (RegW'(cb) << {cnt_q, 3'b000});
  assign imm_sext      = {{(RegW/2){imm_word[RegW/2-1]}}, imm_word[RegW/2-1:0]};

  assign mul_ll = RegW'(acc_q[RegW/2-1:0]) * RegW'(sec_q[RegW/2-1:0]);
  assign mul_x  = acc_q[RegW/2-1:0] * sec_q[RegW-1:RegW/2]
                + acc_q[RegW-1:RegW/2] * sec_q[RegW/2-1:0];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    imm_d   = imm_q;
    op_d    = op_q;
    acc_d   = acc_q;
    sec_d   = sec_q;
    ptr_d   = ptr_q;
    st_d    = st_q;
    if (cfg_we_i) begin
      phase_d = PH_PRE0;
      cnt_d   = '0;
      imm_d   = '0;
      op_d    = OP_ADD;
      acc_d   = '0;
      sec_d   = '0;
      ptr_d   = cfg_wdata_i;
      st_d    = ST_RUN;
    end else if (in_acc && st_q == ST_RUN) begin
      ptr_d = ptr_q + RegW'(1);
      unique case (phase_q)
        PH_PRE0: begin
          if (cb == OpcRexW) phase_d = PH_PRE1;
          else st_d = ST_FAIL;
        end
        PH_PRE1: begin
          if (cb == OpcMovRax) begin
            phase_d = PH_IMM_ACC;
            cnt_d   = '0;
            imm_d   = '0;
          end else begin
            st_d = ST_FAIL;
          end
        end
        PH_IMM_ACC: begin
          imm_d = imm_word;
          if (cnt_q == 3'd7) begin
            cnt_d   = '0;
            acc_d   = imm_word;
            phase_d = PH_OPCODE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_OPCODE: begin
          priority if (cb == OpcGrp5) begin
            phase_d = PH_JMPREG;
          end else if (cb == OpcJmpRel) begin
            phase_d = PH_REL;
            cnt_d   = '0;
            imm_d   = '0;
          end else if (cb == OpcRexW) begin
            phase_d = PH_P48;
          end else if (cb == OpcRexWB) begin
            phase_d = PH_P49;
          end else begin
            st_d = ST_FAIL;
          end
        end
        PH_JMPREG: begin
          st_d = (cb == ModrmJmpRax) ? ST_OK : ST_FAIL;
        end
        PH_REL: begin
          imm_d = imm_word;
          if (cnt_q == 3'd3) begin
            cnt_d   = '0;
            ptr_d   = ptr_q + imm_sext + RegW'(1);
            phase_d = PH_OPCODE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_P48: begin
          priority if (cb == OpcAddImm || cb == OpcSubImm || cb == OpcXorImm) begin
            phase_d = PH_IMM32;
            cnt_d   = '0;
            imm_d   = '0;
            op_d    = (cb == OpcAddImm) ? OP_ADD : (cb == OpcSubImm) ? OP_SUB : OP_XOR;
          end else begin
            st_d = ST_FAIL;
          end
        end
        PH_IMM32: begin
          imm_d = imm_word;
          if (cnt_q == 3'd3) begin
            cnt_d   = '0;
            phase_d = PH_OPCODE;
            unique case (op_q)
              OP_ADD:  acc_d = acc_q + imm_sext;
              OP_SUB:  acc_d = acc_q - imm_sext;
              default: acc_d = acc_q ^ imm_sext;
            endcase
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_P49: begin
          priority if (cb == OpcEscape) begin
            phase_d = PH_TWO_BYTE;
          end else if (cb == OpcMovR10) begin
            phase_d = PH_IMM_SEC;
            cnt_d   = '0;
            imm_d   = '0;
          end else begin
            st_d = ST_FAIL;
          end
        end
        PH_IMM_SEC: begin
          imm_d = imm_word;
          if (cnt_q == 3'd7) begin
            cnt_d   = '0;
            sec_d   = imm_word;
            phase_d = PH_OPCODE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_TWO_BYTE: begin
          if (cb == OpcImul) phase_d = PH_MODRM;
          else st_d = ST_FAIL;
        end
        PH_MODRM: begin
          if (cb == ModrmRaxR10) begin
            acc_d   = prod_q;
            phase_d = PH_OPCODE;
          end else begin
            st_d = ST_FAIL;
          end
        end
        default: st_d = ST_FAIL;
      endcase
    end
  end

  assign out_valid_d = in_acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PRE0;
      cnt_q       <= '0;
      imm_q       <= '0;
      op_q        <= OP_ADD;
      acc_q       <= '0;
      sec_q       <= '0;
      ptr_q       <= StartAddrRst;
      st_q        <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      imm_q       <= imm_d;
      op_q        <= op_d;
      acc_q       <= acc_d;
      sec_q       <= sec_d;
      ptr_q       <= ptr_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_ll_q <= mul_ll;
    mul_x_q  <= mul_x;
    prod_q   <= mul_ll_q + {mul_x_q, {(RegW/2){1'b0}}};
    if (in_acc) begin
      out_data_q <= {{(OutDataW-OutFieldsW){1'b0}}, sec_d, acc_d, st_d, ptr_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/ose_checker.sv =====
// Port-level checks for the stub evaluator, bound to its top level.
// Depends on ose_pkg and obfuscated_stub_evaluator.
module ose_checker
  import ose_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !s_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result repeated without a new word");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !s_axis_tvalid && !m_axis_tvalid)
    else $error("start address written with a word in flight");

endmodule

bind obfuscated_stub_evaluator ose_checker u_ose_checker (.*);
